// ===== rtl/bfa_pkg.sv =====
`default_nettype none
package bfa_pkg;

    localparam int FRAME_COUNT_DEF = 4096;
    localparam int TOP_ORDER_DEF   = 10;

    // frame status codes
    localparam logic [4:0] FS_MEMBER = 5'd31;
    localparam logic [4:0] FS_ALLOC  = 5'd30;
    localparam logic [4:0] GO_NONE   = 5'd31;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_MEM   = 3'd1;
    localparam logic [2:0] ST_BAD_IDX  = 3'd2;
    localparam logic [2:0] ST_NOT_ALOC = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [12:0] frames_requested;
        logic [12:0] frame_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] block_index;
        logic [3:0]  block_order;
    } t_rsp;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_AFIND,
        S_AREM,
        S_ASPLIT,
        S_APP,
        S_LNK,
        S_FGO,
        S_FCHK,
        S_FTST,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/buddy_frame_allocator.sv =====
// Buddy frame allocator.
// Input channel (i_in_valid / o_in_ready, i_in_data): one beat is an allocate
// or a free request. Output channel (o_out_valid / i_out_ready, o_out_data):
// exactly one response beat per request, in request order.
// One request is in flight at a time; o_in_ready is high only when idle.
// An allocate finds the lowest non-empty list, removes its head block, then
// splits: each split step appends the upper buddy to a list tail and links it.
// A free reads the block's granted order, checks buddies (read, test, unlink on
// a merge), then appends and links the result. Each list unlink, link or status
// update is its own access to the single-port frame memories.
// After reset the block sweeps its frame memories, one frame per cycle,
// through all FRAME_COUNT frames before it first raises o_in_ready.
// A stalled receiver holds the response in the output register; the next
// request is taken only after that beat has gone.
`default_nettype none
module buddy_frame_allocator
    import bfa_pkg::*;
#(
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int TOP_ORDER   = TOP_ORDER_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int LW = $clog2(FRAME_COUNT + 1);
    localparam int OW = $clog2(TOP_ORDER + 1);
    localparam int NBLK = FRAME_COUNT >> TOP_ORDER;
    localparam logic [LW-1:0] NIL = LW'(FRAME_COUNT);
    localparam logic [LW-1:0] ONE = LW'(1);
    localparam logic [31:0] BSZ = 32'(1) << TOP_ORDER;
    localparam logic [LW-1:0] HEAD_RST = (NBLK > 0) ? LW'(0) : NIL;
    localparam logic [LW-1:0] TAIL_RST = (NBLK > 0) ? LW'((NBLK - 1) * (1 << TOP_ORDER)) : NIL;

    t_state r_state, n_state;

    logic [IW-1:0] r_clr;
    logic          r_op;
    logic [OW-1:0] r_want, n_want;
    logic [OW-1:0] r_ord, n_ord;
    logic [LW-1:0] r_blk, n_blk;
    logic [LW-1:0] r_bud, n_bud;
    logic [LW-1:0] r_lt;
    t_rsp          r_res, n_res;

    logic [LW-1:0] r_head [TOP_ORDER+1];
    logic [LW-1:0] r_tail [TOP_ORDER+1];

    // frame memories
    logic [4:0]    m_fs  [FRAME_COUNT];
    logic [4:0]    m_go  [FRAME_COUNT];
    logic [LW-1:0] m_nxt [FRAME_COUNT];
    logic [LW-1:0] m_prv [FRAME_COUNT];
    logic [4:0]    r_fs_q, r_go_q;
    logic [LW-1:0] r_nxt_q, r_prv_q;

    logic          rd_en;
    logic [IW-1:0] rd_a;
    logic          fs_we, go_we, nxt_we, prv_we;
    logic [IW-1:0] fs_wa, go_wa, nxt_wa, prv_wa;
    logic [4:0]    fs_wd, go_wd;
    logic [LW-1:0] nxt_wd, prv_wd;

    // request decode
    logic [31:0]   req_n, req_m;
    logic          req_bad;
    logic [OW-1:0] req_want;
    always_comb begin
        int w;
        w = 0;
        req_n   = 32'(i_in_data.frames_requested);
        req_m   = req_n - 32'd1;
        req_bad = (req_n == 32'd0) || (req_n > BSZ);
        for (int k = 0; k < 13; k++) begin
            if (req_m[k]) begin
                w = k + 1;
            end
        end
        req_want = OW'(w);
    end

    // lowest non-empty list at or above the wanted order
    logic          fnd;
    logic [OW-1:0] fnd_ord;
    always_comb begin
        fnd     = 1'b0;
        fnd_ord = '0;
        for (int k = 0; k <= TOP_ORDER; k++) begin
            if (!fnd && OW'(k) >= r_want && r_head[k] < NIL) begin
                fnd     = 1'b1;
                fnd_ord = OW'(k);
            end
        end
    end

    logic [LW-1:0] cur_head, cur_tail, app_f, rm_f, mrg_bud, spl_bud;
    logic          rm_hit;
    assign cur_head = r_head[r_ord];
    assign cur_tail = r_tail[r_ord];
    assign app_f    = (r_op == OP_FREE) ? r_blk : r_bud;
    assign rm_f     = (r_state == S_AREM) ? r_blk : r_bud;
    assign mrg_bud  = r_blk ^ (ONE << r_ord);
    assign spl_bud  = r_blk ^ (ONE << (r_ord - OW'(1)));
    assign rm_hit   = (r_state == S_AREM) || (r_state == S_FTST && r_fs_q == 5'(r_ord));

    // clearing pass values
    logic [31:0]   clr_i;
    logic          clr_head;
    logic [LW-1:0] clr_nxt, clr_prv;
    always_comb begin
        clr_i    = 32'(r_clr);
        clr_head = ((clr_i & (BSZ - 32'd1)) == 32'd0) && (clr_i + BSZ <= 32'(FRAME_COUNT));
        clr_nxt  = (clr_i + BSZ + BSZ <= 32'(FRAME_COUNT)) ? LW'(clr_i + BSZ) : NIL;
        clr_prv  = (clr_i >= BSZ) ? LW'(clr_i - BSZ) : NIL;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:    if (r_clr == IW'(FRAME_COUNT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.opcode == OP_ALLOC) begin
                        n_state = req_bad ? S_DONE : S_AFIND;
                    end else begin
                        n_state = (32'(i_in_data.frame_index) >= 32'(FRAME_COUNT)) ?
                                  S_DONE : S_FGO;
                    end
                end
            end
            S_AFIND:  n_state = fnd ? S_AREM : S_DONE;
            S_AREM:   n_state = S_ASPLIT;
            S_ASPLIT: begin
                if (r_ord > r_want) begin
                    n_state = (spl_bud < NIL) ? S_APP : S_ASPLIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_APP:    n_state = S_LNK;
            S_LNK:    n_state = (r_op == OP_FREE) ? S_DONE : S_ASPLIT;
            S_FGO:    n_state = (r_go_q > 5'(TOP_ORDER)) ? S_DONE : S_FCHK;
            S_FCHK: begin
                n_state = (r_ord < OW'(TOP_ORDER) && mrg_bud < NIL) ? S_FTST : S_APP;
            end
            S_FTST:   n_state = rm_hit ? S_FCHK : S_APP;
            S_DONE:   if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_CLR;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_want = r_want;
        n_ord  = r_ord;
        n_blk  = r_blk;
        n_bud  = r_bud;
        n_res  = r_res;
        rd_en  = 1'b0;
        rd_a   = '0;
        fs_we  = 1'b0;  fs_wa  = '0;  fs_wd  = '0;
        go_we  = 1'b0;  go_wa  = '0;  go_wd  = '0;
        nxt_we = 1'b0;  nxt_wa = '0;  nxt_wd = '0;
        prv_we = 1'b0;  prv_wa = '0;  prv_wd = '0;
        case (r_state)
            S_CLR: begin
                fs_we  = 1'b1; fs_wa  = r_clr; fs_wd = clr_head ? 5'(TOP_ORDER) : FS_MEMBER;
                go_we  = 1'b1; go_wa  = r_clr; go_wd = GO_NONE;
                nxt_we = 1'b1; nxt_wa = r_clr; nxt_wd = clr_head ? clr_nxt : NIL;
                prv_we = 1'b1; prv_wa = r_clr; prv_wd = clr_head ? clr_prv : NIL;
            end
            S_IDLE: begin
                n_want = req_want;
                n_blk  = LW'(i_in_data.frame_index);
                rd_en  = 1'b1;
                rd_a   = i_in_data.frame_index[IW-1:0];
                n_res  = '0;
                if (i_in_data.opcode == OP_ALLOC) begin
                    if (req_bad) n_res.status = ST_BAD_SIZE;
                end else if (32'(i_in_data.frame_index) >= 32'(FRAME_COUNT)) begin
                    n_res.status = ST_BAD_IDX;
                end
            end
            S_AFIND: begin
                n_ord = fnd_ord;
                n_blk = r_head[fnd_ord];
                rd_en = 1'b1;
                rd_a  = r_head[fnd_ord][IW-1:0];
                if (!fnd) n_res.status = ST_NO_MEM;
            end
            S_AREM: begin
                fs_we = 1'b1; fs_wa = r_blk[IW-1:0]; fs_wd = FS_ALLOC;
                go_we = 1'b1; go_wa = r_blk[IW-1:0]; go_wd = 5'(r_want);
            end
            S_ASPLIT: begin
                if (r_ord > r_want) begin
                    n_ord = r_ord - OW'(1);
                    n_bud = spl_bud;
                end else begin
                    n_res.block_index = 12'(r_blk);
                    n_res.block_order = 4'(r_want);
                end
            end
            S_APP: begin
                fs_we  = 1'b1; fs_wa  = app_f[IW-1:0]; fs_wd  = 5'(r_ord);
                prv_we = 1'b1; prv_wa = app_f[IW-1:0]; prv_wd = cur_tail;
                nxt_we = 1'b1; nxt_wa = app_f[IW-1:0]; nxt_wd = NIL;
            end
            S_LNK: begin
                if (r_lt < NIL) begin
                    nxt_we = 1'b1; nxt_wa = r_lt[IW-1:0]; nxt_wd = app_f;
                end
                n_res.block_index = 12'(r_blk);
                n_res.block_order = 4'(r_ord);
            end
            S_FGO: begin
                if (r_go_q > 5'(TOP_ORDER)) begin
                    n_res.status = ST_NOT_ALOC;
                end else begin
                    n_ord = OW'(r_go_q);
                    go_we = 1'b1; go_wa = r_blk[IW-1:0]; go_wd = GO_NONE;
                end
            end
            S_FCHK: begin
                n_bud = mrg_bud;
                rd_en = 1'b1;
                rd_a  = mrg_bud[IW-1:0];
            end
            S_FTST: begin
                if (rm_hit) begin
                    n_ord = r_ord + OW'(1);
                    if (r_bud < r_blk) n_blk = r_bud;
                end
            end
            default: ;
        endcase
        // unlink from a list
        if (rm_hit) begin
            if (r_prv_q < NIL) begin
                nxt_we = 1'b1; nxt_wa = r_prv_q[IW-1:0]; nxt_wd = r_nxt_q;
            end
            if (r_nxt_q < NIL) begin
                prv_we = 1'b1; prv_wa = r_nxt_q[IW-1:0]; prv_wd = r_prv_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fs_we)  m_fs[fs_wa]   <= fs_wd;
        if (go_we)  m_go[go_wa]   <= go_wd;
        if (nxt_we) m_nxt[nxt_wa] <= nxt_wd;
        if (prv_we) m_prv[prv_wa] <= prv_wd;
        if (rd_en) begin
            r_fs_q  <= m_fs[rd_a];
            r_go_q  <= m_go[rd_a];
            r_nxt_q <= m_nxt[rd_a];
            r_prv_q <= m_prv[rd_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            for (int k = 0; k <= TOP_ORDER; k++) begin
                r_head[k] <= (k == TOP_ORDER) ? HEAD_RST : NIL;
                r_tail[k] <= (k == TOP_ORDER) ? TAIL_RST : NIL;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + IW'(1);
            if (rm_hit) begin
                if (cur_head == rm_f) r_head[r_ord] <= r_nxt_q;
                if (cur_tail == rm_f) r_tail[r_ord] <= r_prv_q;
            end
            if (r_state == S_APP) begin
                r_tail[r_ord] <= app_f;
                if (cur_tail >= NIL) r_head[r_ord] <= app_f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) r_op <= i_in_data.opcode;
        if (r_state == S_APP)  r_lt <= cur_tail;
        r_want <= n_want;
        r_ord  <= n_ord;
        r_blk  <= n_blk;
        r_bud  <= n_bud;
        r_res  <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out_data  = r_res;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench
    import bfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFR = FRAME_COUNT_DEF;
    localparam int TOPO = TOP_ORDER_DEF;
    localparam int NIL = NFR;
    localparam int RAND_BEATS = 1930;
    localparam longint CYCLE_LIMIT = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    t_req i_in_data = '0;
    logic o_in_ready, o_out_valid;
    t_rsp o_out_data;

    buddy_frame_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // shadow allocator state
    logic [4:0] fstate [NFR];
    logic [4:0] gorder [NFR];
    int nxt [NFR];
    int prv [NFR];
    int lhead [TOPO+1];
    int ltail [TOPO+1];
    int granted_q[$];          // block starts currently granted

    t_rsp rsp_pending[$];
    int errors = 0;
    int row_errors = 0;
    int rsp_seen = 0;
    int n_alloc_ok = 0, n_err = 0;
    longint cycle = 0;
    bit rx_hold = 0;
    bit idle_free = 0;

    function automatic void link_tail(int f, int o);
        int t;
        t = ltail[o];
        nxt[f] = NIL;
        if (t >= NIL) begin
            prv[f] = NIL;
            lhead[o] = f;
        end else begin
            prv[f] = t;
            nxt[t] = f;
        end
        ltail[o] = f;
    endfunction

    function automatic void unlink(int f, int o);
        int p, n;
        p = prv[f];
        n = nxt[f];
        if (p < NIL) nxt[p] = n;
        if (n < NIL) prv[n] = p;
        if (lhead[o] == f) lhead[o] = n;
        if (ltail[o] == f) ltail[o] = p;
        nxt[f] = NIL;
        prv[f] = NIL;
    endfunction

    function automatic void mark_block(int s, int o, logic [4:0] v);
        for (int k = 0; k < (1 << o); k++)
            if (s + k < NIL) fstate[s + k] = v;
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < NFR; i++) begin
            fstate[i] = FS_MEMBER;
            gorder[i] = GO_NONE;
            nxt[i] = NIL;
            prv[i] = NIL;
        end
        for (int o = 0; o <= TOPO; o++) begin
            lhead[o] = NIL;
            ltail[o] = NIL;
        end
        for (int i = 0; i + (1 << TOPO) <= NFR; i += (1 << TOPO)) begin
            fstate[i] = 5'(TOPO);
            link_tail(i, TOPO);
        end
        granted_q.delete();
    endfunction

    function automatic t_rsp predict_allocator(t_req r);
        t_rsp p;
        int n, want, a, blk, bud, b, t, f;
        bit found;
        p = '0;
        if (r.opcode == OP_ALLOC) begin
            n = int'(r.frames_requested);
            if (n == 0 || n > (1 << TOPO)) begin
                p.status = ST_BAD_SIZE;
            end else begin
                want = 0;
                while ((1 << want) < n) want++;
                found = 0;
                for (a = want; a <= TOPO; a++)
                    if (lhead[a] < NIL) begin
                        found = 1;
                        break;
                    end
                if (!found) begin
                    p.status = ST_NO_MEM;
                end else begin
                    blk = lhead[a];
                    unlink(blk, a);
                    while (a > want) begin
                        a--;
                        bud = blk ^ (1 << a);
                        if (bud < NIL) begin
                            fstate[bud] = 5'(a);
                            link_tail(bud, a);
                        end
                    end
                    mark_block(blk, want, FS_ALLOC);
                    gorder[blk] = 5'(want);
                    granted_q.push_back(blk);
                    p.block_index = 12'(blk);
                    p.block_order = 4'(want);
                end
            end
        end else begin
            f = int'(r.frame_index);
            if (f >= NIL) begin
                p.status = ST_BAD_IDX;
            end else if (gorder[f] > TOPO) begin
                p.status = ST_NOT_ALOC;
            end else begin
                b = int'(gorder[f]);
                t = f;
                gorder[f] = GO_NONE;
                foreach (granted_q[k])
                    if (granted_q[k] == f) begin
                        granted_q.delete(k);
                        break;
                    end
                while (b < TOPO) begin
                    bud = t ^ (1 << b);
                    if (bud < NIL && fstate[bud] == b) begin
                        unlink(bud, b);
                        if (bud < t) t = bud;
                        b++;
                    end else begin
                        break;
                    end
                end
                link_tail(t, b);
                mark_block(t, b, FS_MEMBER);
                fstate[t] = 5'(b);
                p.block_index = 12'(t);
                p.block_order = 4'(b);
            end
        end
        return p;
    endfunction

    function automatic bit predict_peek_ok(t_req r);
        int w;
        w = 0;
        if (r.frames_requested == 0 || r.frames_requested > (1 << TOPO)) return 0;
        while ((1 << w) < r.frames_requested) w++;
        for (int a = w; a <= TOPO; a++)
            if (lhead[a] < NIL) return 1;
        return 0;
    endfunction

    function automatic t_req mk_alloc(int n);
        t_req r;
        r = '0;
        r.opcode = OP_ALLOC;
        r.frames_requested = 13'(n);
        r.frame_index = 13'($urandom_range(0, 8191));
        return r;
    endfunction

    function automatic t_req mk_free(int f);
        t_req r;
        r = '0;
        r.opcode = OP_FREE;
        r.frame_index = 13'(f);
        r.frames_requested = 13'($urandom_range(0, 8191));
        return r;
    endfunction

    // sends one beat; idling inserted at random unless disabled
    task automatic send_beat(t_req r);
        while (!idle_free && $urandom_range(0, 99) < 37) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_data <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rsp_pending.push_back(predict_allocator(r));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (rsp_pending.size() != 0) @(negedge i_clk);
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (rx_hold)
            i_out_ready <= 1'b0;
        else if (idle_free)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(0, 99) >= 37);
    end

    always @(posedge i_clk) begin
        t_rsp want_rsp;
        cycle <= cycle + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (rsp_pending.size() == 0) begin
                $display("%0t: response with nothing pending: %p", $realtime, o_out_data);
                errors <= errors + 1;
            end else begin
                want_rsp = rsp_pending.pop_front();
                if (want_rsp.status != ST_OK) n_err <= n_err + 1;
                if (o_out_data.status !== want_rsp.status ||
                    o_out_data.block_index !== want_rsp.block_index ||
                    o_out_data.block_order !== want_rsp.block_order) begin
                    $display("%0t: mismatch expected st=%0d idx=%0d ord=%0d got st=%0d idx=%0d ord=%0d",
                             $realtime, want_rsp.status, want_rsp.block_index,
                             want_rsp.block_order, o_out_data.status,
                             o_out_data.block_index, o_out_data.block_order);
                    errors <= errors + 1;
                end
            end
        end
        if (cycle > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d, %0d responses pending", cycle, rsp_pending.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    typedef struct {
        t_req req;
        bit   fixed;     // expected value typed in below
        t_rsp rsp;
    } t_row;

    t_row script[$];

    function automatic t_rsp r3(logic [2:0] s, int i, int o);
        t_rsp p;
        p.status = s;
        p.block_index = 12'(i);
        p.block_order = 4'(o);
        return p;
    endfunction

    function automatic void add_row(t_req r, bit fx, t_rsp p);
        t_row w;
        w.req = r;
        w.fixed = fx;
        w.rsp = p;
        script.push_back(w);
    endfunction

    initial begin
        t_req r;
        t_rsp got;
        int pick, k, hold;

        shadow_reset();
        // directed table
        add_row(mk_free(0), 1, r3(ST_NOT_ALOC, 0, 0));
        add_row(mk_alloc(0), 1, r3(ST_BAD_SIZE, 0, 0));
        add_row(mk_alloc(1025), 1, r3(ST_BAD_SIZE, 0, 0));
        add_row(mk_alloc(8191), 1, r3(ST_BAD_SIZE, 0, 0));
        add_row(mk_free(4096), 1, r3(ST_BAD_IDX, 0, 0));
        add_row(mk_free(8191), 1, r3(ST_BAD_IDX, 0, 0));
        add_row(mk_alloc(1), 1, r3(ST_OK, 0, 0));
        add_row(mk_alloc(1024), 1, r3(ST_OK, 1024, 10));
        add_row(mk_alloc(1024), 1, r3(ST_OK, 2048, 10));
        add_row(mk_alloc(1024), 0, '0);  // takes the last block at top order
        add_row(mk_alloc(3), 0, '0);
        add_row(mk_alloc(513), 0, '0);
        add_row(mk_free(1), 1, r3(ST_NOT_ALOC, 0, 0));
        add_row(mk_free(0), 0, '0);
        add_row(mk_free(0), 1, r3(ST_NOT_ALOC, 0, 0));
        add_row(mk_free(1024), 0, '0);
        add_row(mk_free(2048), 0, '0);
        add_row(mk_alloc(1024), 0, '0);
        add_row(mk_alloc(1024), 0, '0);
        add_row(mk_alloc(1024), 0, '0);
        add_row(mk_alloc(1024), 0, '0);
        add_row(mk_alloc(1), 0, '0);      // granted, split from the order-2 block at frame 0
        add_row(mk_free(4095), 0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            // table expectations are checked against the shadow too
            send_beat(script[i].req);
            if (script[i].fixed) begin
                got = rsp_pending[$];
                if (got != script[i].rsp) begin
                    $display("%0t: directed row %0d expected %p, shadow gives %p",
                             $realtime, i, script[i].rsp, got);
                    row_errors++;
                end
            end
        end
        wait_drained();
        // release whatever the table left granted
        while (granted_q.size() != 0) send_beat(mk_free(granted_q[0]));

        for (int i = 0; i < RAND_BEATS; i++) begin
            if (i == 300) begin
                // receiver stalls while requests keep coming
                rx_hold = 1;
                fork
                    begin
                        hold = 0;
                        while (hold < 400) begin
                            @(posedge i_clk);
                            hold++;
                        end
                        rx_hold = 0;
                    end
                join_none
            end
            if (i == 700) begin
                wait_drained();
                repeat (50) @(negedge i_clk);
            end
            idle_free = (i >= 1000 && i < 1200);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                k = $urandom_range(0, 99);
                if (k < 70) r = mk_alloc($urandom_range(1, 16));
                else if (k < 92) r = mk_alloc($urandom_range(1, 1024));
                else if (k < 96) r = mk_alloc($urandom_range(0, 8191));
                else r = mk_alloc(0);
            end else if (pick < 90 && granted_q.size() != 0) begin
                r = mk_free(granted_q[$urandom_range(0, granted_q.size() - 1)]);
            end else begin
                r = mk_free($urandom_range(0, 8191));
            end
            if (r.opcode == OP_ALLOC && predict_peek_ok(r)) n_alloc_ok++;
            send_beat(r);
        end
        idle_free = 0;
        wait_drained();
        repeat (60) @(negedge i_clk);
        $display("covered %0d responses over %0d cycles, %0d error replies",
                 rsp_seen, cycle, n_err);
        $display("random phase granted %0d allocations, with a long receiver stall and a drain",
                 n_alloc_ok);
        if (errors == 0 && row_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
